// File: design/jss_pkg.sv
`timescale 1ns / 1ps

package jss_pkg;

   localparam int MAX_SCAN_BITS = 32;
   localparam int RESET_STROBES = 5;

   localparam int DATA_W    = 32;
   localparam int CNT_W     = 6;
   localparam int STEP_W    = $clog2(MAX_SCAN_BITS + 1);
   localparam int CMP_W     = (STEP_W > CNT_W) ? STEP_W : CNT_W;
   localparam int CAP_IDX_W = $clog2(DATA_W);

   // tms preamble from run-test idle to the shift state
   localparam int IR_PRE_LEN   = 4;
   localparam int IR_PRE_HIGHS = 2;
   localparam int DR_PRE_LEN   = 3;
   localparam int DR_PRE_HIGHS = 1;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_RESET = 2'd1,
      ACT_IR    = 2'd2,
      ACT_DR    = 2'd3
   } action_type;

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_RST_HI = 7'b0000010,
      PH_RST_LO = 7'b0000100,
      PH_PRE    = 7'b0001000,
      PH_SHIFT  = 7'b0010000,
      PH_UPD    = 7'b0100000,
      PH_RTI    = 7'b1000000
   } phase_type;

   typedef struct packed {
      phase_type                 phase;
      logic                      scan_is_ir;
      logic [STEP_W-1:0]         step_index;
      logic [STEP_W-1:0]         scan_length;
      logic [MAX_SCAN_BITS-1:0]  out_shift;
      logic [DATA_W-1:0]         in_capture;
   } state_type;

   typedef struct packed {
      logic              tck_pulse;
      logic              tms;
      logic              tdi;
      logic              busy_res;
      logic              done_res;
      logic [DATA_W-1:0] captured;
   } result_type;

endpackage

// File: design/jss_step.sv
`timescale 1ns / 1ps

module jss_step (
   input  jss_pkg::state_type          state_cur,
   input  logic [1:0]                  action,
   input  logic [jss_pkg::DATA_W-1:0]  shift_out,
   input  logic [jss_pkg::CNT_W-1:0]   bit_count,
   input  logic                        tdo,
   output jss_pkg::state_type          state_nxt,
   output jss_pkg::result_type         result
);
   import jss_pkg::*;

   state_type          cur;
   state_type          nxt;
   result_type         res;
   logic               is_idle;
   logic [CMP_W-1:0]   cnt_sat;
   logic [STEP_W-1:0]  step_inc;
   logic [CAP_IDX_W-1:0] cap_idx;

   always_comb begin
      cur      = state_cur;
      res      = '0;
      is_idle  = !(state_cur.phase inside {PH_RST_HI, PH_RST_LO, PH_PRE, PH_SHIFT,
                                           PH_UPD, PH_RTI});
      cnt_sat  = CMP_W'(bit_count);
      if (cnt_sat == '0) begin
         cnt_sat = CMP_W'(1);
      end
      if (cnt_sat > CMP_W'(MAX_SCAN_BITS)) begin
         cnt_sat = CMP_W'(MAX_SCAN_BITS);
      end

      if (is_idle) begin
         cur.phase = PH_IDLE;
      end

      // a command is taken only while idle and issues its first strobe at once
      if (is_idle && (action != ACT_TICK)) begin
         cur.step_index = '0;
         if (action == ACT_RESET) begin
            cur.scan_is_ir = 1'b0;
            cur.phase      = PH_RST_HI;
         end else begin
            cur.scan_is_ir  = (action == ACT_IR);
            cur.scan_length = STEP_W'(cnt_sat);
            cur.out_shift   = MAX_SCAN_BITS'(shift_out);
            cur.in_capture  = '0;
            cur.phase       = PH_PRE;
         end
      end

      nxt      = cur;
      step_inc = cur.step_index + 1'b1;
      cap_idx  = CAP_IDX_W'(cur.step_index);

      case (cur.phase)
         PH_RST_HI: begin
            res.tms        = 1'b1;
            nxt.step_index = step_inc;
            if (int'(step_inc) >= RESET_STROBES) begin
               nxt.step_index = '0;
               nxt.phase      = PH_RST_LO;
            end
         end
         PH_RST_LO: begin
            res.done_res = 1'b1;
            nxt.phase    = PH_IDLE;
         end
         PH_PRE: begin
            if (cur.scan_is_ir) begin
               res.tms = (int'(cur.step_index) < IR_PRE_HIGHS);
            end else begin
               res.tms = (int'(cur.step_index) < DR_PRE_HIGHS);
            end
            nxt.step_index = step_inc;
            if (int'(step_inc) >= (cur.scan_is_ir ? IR_PRE_LEN : DR_PRE_LEN)) begin
               nxt.step_index = '0;
               nxt.phase      = PH_SHIFT;
            end
         end
         PH_SHIFT: begin
            res.tdi       = cur.out_shift[0];
            nxt.out_shift = cur.out_shift >> 1;
            if (tdo && (int'(cur.step_index) < DATA_W)) begin
               nxt.in_capture[cap_idx] = 1'b1;
            end
            // tms high on the last bit leaves shift for exit1
            res.tms        = (step_inc >= cur.scan_length);
            nxt.step_index = step_inc;
            if (step_inc >= cur.scan_length) begin
               nxt.step_index = '0;
               nxt.phase      = PH_UPD;
            end
         end
         PH_UPD: begin
            res.tms   = 1'b1;
            nxt.phase = PH_RTI;
         end
         PH_RTI: begin
            res.done_res = 1'b1;
            res.captured = cur.in_capture;
            nxt.phase    = PH_IDLE;
         end
         default: begin
         end
      endcase

      if (cur.phase != PH_IDLE) begin
         res.tck_pulse = 1'b1;
         res.busy_res  = 1'b1;
      end
   end

   assign state_nxt = nxt;
   assign result    = res;

endmodule

// File: design/jtag_scan_sequencer_core.sv
`timescale 1ns / 1ps

// jtag host sequencer: one request beat stands for one tck period
// request: req_action starts a tap reset, ir scan or dr scan while idle
//   (ignored while a sequence runs); req_shift_out and req_bit_count are
//   taken with the start, req_tdo is the target sample for this period
// response: exactly one beat per request beat with the pins for that period
//   (tck strobe, tms, tdi), busy, done and the right-aligned capture on done
// latency: the response beat is valid the cycle after its request beat
// throughput: one beat per cycle unless stalled; the sequencer state and
//   the pin decode sit between the request handshake and one response register
// a tap reset drives tms high, then ends on a done beat; an ir or dr scan
//   runs the tms preamble, shifts n bits, passes update and ends on a done
//   beat in run-test idle, n being req_bit_count clamped to 1..MAX_SCAN_BITS
// reset: synchronous, returns the sequencer to idle and empties the response
// stall: a held response keeps req_ready low unless rsp_ready takes it in
//   the same cycle, so no beat is dropped or reordered
module jtag_scan_sequencer_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic [jss_pkg::DATA_W-1:0]  req_shift_out,
   input  logic [jss_pkg::CNT_W-1:0]   req_bit_count,
   input  logic                        req_tdo,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_tck_pulse,
   output logic                        rsp_tms,
   output logic                        rsp_tdi,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res,
   output logic [jss_pkg::DATA_W-1:0]  rsp_captured
);
   import jss_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   jss_step u_step (
      .state_cur (state_ff),
      .action    (req_action),
      .shift_out (req_shift_out),
      .bit_count (req_bit_count),
      .tdo       (req_tdo),
      .state_nxt (state_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{phase: PH_IDLE, scan_is_ir: 1'b0, step_index: '0,
                           scan_length: '0, out_shift: '0, in_capture: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tck_pulse = rsp_ff.tck_pulse;
   assign rsp_tms       = rsp_ff.tms;
   assign rsp_tdi       = rsp_ff.tdi;
   assign rsp_busy_res  = rsp_ff.busy_res;
   assign rsp_done_res  = rsp_ff.done_res;
   assign rsp_captured  = rsp_ff.captured;

   a_done_in_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.done_res || rsp_ff.busy_res))
      else $error("done beat outside a running sequence");

   a_capture_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.captured != '0)) |-> rsp_ff.done_res)
      else $error("capture data outside a done beat");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (state_ff.phase == PH_IDLE) && (req_action != ACT_TICK))
      |=> (state_ff.phase != PH_IDLE))
      else $error("command beat did not start a sequence");

   a_shift_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_SHIFT) |-> (state_ff.scan_length != '0))
      else $error("shift with zero scan length");

endmodule
